// ===== rtl/shared_fitness_roulette_select_unit_assert.svh =====
// Assertion macros shared by the roulette selection RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef SHARED_FITNESS_ROULETTE_SELECT_UNIT_ASSERT_SVH
`define SHARED_FITNESS_ROULETTE_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define SFRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/sfrs_pkg.sv =====
// Package for the shared-fitness roulette selection unit.
// Holds field widths, request codes and the sequencer state type.
`default_nettype none

package sfrs_pkg;

  localparam int MAX_GENOMES_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SUM_W   = 42;
  localparam int POS_W   = 10;
  localparam int FIT_W   = 32;
  localparam int SIZE_W  = 10;
  localparam int RAND_W  = 16;
  localparam int START_W = 10;
  localparam int END_W   = 11;
  localparam int KEPT_W  = 11;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 24;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SELECT = 1'b1;
  localparam logic ANS_LOAD   = 1'b0;
  localparam logic ANS_SELECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_LFIN,
    ST_SEL_LO,
    ST_SEL_HI,
    ST_SEL_HW,
    ST_MUL,
    ST_MULD,
    ST_SRD,
    ST_SCMP,
    ST_PRD,
    ST_PWT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/shared_fitness_roulette_select_unit.sv =====
// Roulette-wheel selection with fitness sharing: sequencer, shared
// divide/multiply datapath and prefix-sum memory. Uses sfrs_pkg and the
// assertion macro header.
//
// Usage: a load run offers genomes on the in_ stream (in_tuser = load) and
// ends with in_tlast; kept genomes add fitness/species_size to a saturating
// prefix sum in memory, and the last load request returns one report with
// the kept count. Select requests return the position of the genome owning
// the drawn point, or ok = 0 for an invalid range or while a load is open.
// A kept load request with a species runs the bit-serial restoring divider,
// then the add and memory write, then finishes; one without a species skips
// the divider, a dropped genome only finishes, and the last request of a
// run also hands over its report. A valid select runs the shift-add
// multiplier, then scans the prefix sums one at a time through the single
// read port of the memory (none when the range's sums are equal); an invalid
// select goes straight to its result.
// in_tready is high only while the sequencer is idle. A finished result is
// held in the output register until taken; the block still takes the next
// request meanwhile, and waits only when a second result is due.
// Reset (rst_n low, synchronous) clears the kept count, running sum,
// open-load flag, skip_stagnant and out valid; memories are not cleared.
`default_nettype none

`include "shared_fitness_roulette_select_unit_assert.svh"

module shared_fitness_roulette_select_unit #(
  parameter int MAX_GENOMES   = sfrs_pkg::MAX_GENOMES_DEF,
  parameter int FRACTION_BITS = sfrs_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // Configuration: skip_stagnant in bit 0
  input  wire                             cfg_wr_en,
  input  wire                             cfg_wr_data,
  // Request stream
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // tdata from bit 0: genome_position(10), fitness(32), species_size(10),
  // species_reproducible(1), random_fraction(16), range_start(10),
  // range_end(11), zero padding(6)
  input  wire [sfrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire                             in_tuser,   // req_type
  input  wire                             in_tlast,   // load_last
  // Result stream
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // tdata from bit 0: selected_position(10), kept_count(11), ok(1),
  // zero padding(2)
  output logic [sfrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser   // answer_kind
);

  import sfrs_pkg::*;

  localparam int AW  = $clog2(MAX_GENOMES);
  localparam int KW  = $clog2(MAX_GENOMES + 1);
  localparam int CW  = (KW > END_W) ? KW : END_W;
  localparam int PW  = SUM_W + FRACTION_BITS;
  localparam int STW = 6;

  // Unpacked request fields
  logic [POS_W-1:0]   f_pos;
  logic [FIT_W-1:0]   f_fit;
  logic [SIZE_W-1:0]  f_size;
  logic               f_repro;
  logic [RAND_W-1:0]  f_rand;
  logic [START_W-1:0] f_start;
  logic [END_W-1:0]   f_end;
  logic [31:0]        rand_ext;

  assign f_pos    = in_tdata[9:0];
  assign f_fit    = in_tdata[41:10];
  assign f_size   = in_tdata[51:42];
  assign f_repro  = in_tdata[52];
  assign f_rand   = in_tdata[68:53];
  assign f_start  = in_tdata[78:69];
  assign f_end    = in_tdata[89:79];
  assign rand_ext = 32'(f_rand);

  // Registers
  state_t             state_r, state_nxt;
  logic               skip_r;
  logic               load_open_r, load_open_nxt;
  logic [KW-1:0]      kept_r, kept_nxt;
  logic [SUM_W-1:0]   run_r, run_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic               last_r, last_nxt;
  logic [FRACTION_BITS-1:0] rf_r, rf_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [END_W-1:0]   end_r, end_nxt;
  logic [SUM_W-1:0]   lo_r, lo_nxt;
  logic [SUM_W-1:0]   hi_r, hi_nxt;
  logic [SUM_W-1:0]   v_r, v_nxt;
  logic [PW-1:0]      acc_r, acc_nxt;
  logic [PW-1:0]      mc_r, mc_nxt;
  logic [FIT_W-1:0]   q_r, q_nxt;
  logic [SIZE_W-1:0]  rem_r, rem_nxt;
  logic [STW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               res_kind_r, res_kind_nxt;
  logic [POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [KEPT_W-1:0]  out_kept_r, out_kept_nxt;
  logic               out_ok_r, out_ok_nxt;

  // Memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [SUM_W-1:0]   mem_wsum;
  logic [AW-1:0]      sum_raddr;
  logic [AW-1:0]      pos_raddr;
  logic [SUM_W-1:0]   sum_rd_r;
  logic [POS_W-1:0]   pos_rd_r;

  logic [SUM_W-1:0]   sum_mem [MAX_GENOMES];
  logic [POS_W-1:0]   pos_mem [MAX_GENOMES];

  // Prefix-sum and position memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= mem_wsum;
      pos_mem[mem_waddr] <= pos_r;
    end
    sum_rd_r <= sum_mem[sum_raddr];
    pos_rd_r <= pos_mem[pos_raddr];
  end

  // Datapath helpers
  logic               in_acc;
  logic [KW-1:0]      kept_eff;
  logic               keep;
  logic [SIZE_W:0]    div_shift;
  logic               div_ge;
  logic [SUM_W:0]     sum_wide;
  logic               sel_bad;
  logic [SUM_W-1:0]   prod;
  logic [CW-1:0]      pick;
  logic [CW-1:0]      end_m1;

  assign in_acc    = in_tvalid && in_tready;
  assign kept_eff  = load_open_r ? kept_r : '0;
  assign keep      = (f_fit != '0) && (!skip_r || f_repro) &&
                     (kept_eff < KW'(MAX_GENOMES));
  assign div_shift = {rem_r, q_r[FIT_W-1]};
  assign div_ge    = div_shift >= {1'b0, size_r};
  assign sum_wide  = {1'b0, run_r} + (SUM_W + 1)'(q_r);
  assign sel_bad   = load_open_r || (CW'(f_start) >= CW'(f_end)) ||
                     (CW'(f_end) > CW'(kept_r));
  assign prod      = acc_r[PW-1:FRACTION_BITS];
  assign end_m1    = CW'(end_r) - CW'(1);
  assign pick      = (CW'(start_r) + CW'(prod) > end_m1) ? end_m1
                                                         : CW'(start_r) + CW'(prod);

  // Sequencer: next state, datapath and result register updates
  always_comb begin
    state_nxt     = state_r;
    load_open_nxt = load_open_r;
    kept_nxt      = kept_r;
    run_nxt       = run_r;
    pos_nxt       = pos_r;
    size_nxt      = size_r;
    last_nxt      = last_r;
    rf_nxt        = rf_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    v_nxt         = v_r;
    acc_nxt       = acc_r;
    mc_nxt        = mc_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    res_kind_nxt  = res_kind_r;
    res_pos_nxt   = res_pos_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_pos_nxt   = out_pos_r;
    out_kept_nxt  = out_kept_r;
    out_ok_nxt    = out_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = kept_r[AW-1:0];
    mem_wsum      = run_r;
    sum_raddr     = idx_r;
    pos_raddr     = idx_r;
    in_tready     = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt   = f_pos;
          size_nxt  = f_size;
          last_nxt  = in_tlast;
          rf_nxt    = rand_ext[FRACTION_BITS-1:0];
          start_nxt = f_start;
          end_nxt   = f_end;
          q_nxt     = f_fit;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          if (in_tuser == REQ_LOAD) begin
            if (!load_open_r) begin
              run_nxt  = '0;
              kept_nxt = '0;
            end
            load_open_nxt = 1'b1;
            if (!keep) begin
              state_nxt = ST_LFIN;
            end else if (f_size != '0) begin
              state_nxt = ST_DIV;
            end else begin
              state_nxt = ST_ACC;
            end
          end else if (sel_bad) begin
            res_kind_nxt = ANS_SELECT;
            res_pos_nxt  = '0;
            res_ok_nxt   = 1'b0;
            state_nxt    = ST_OUT;
          end else begin
            state_nxt = ST_SEL_LO;
          end
        end
      end
      // One quotient bit per cycle
      ST_DIV: begin
        rem_nxt = div_ge ? SIZE_W'(div_shift - {1'b0, size_r}) : div_shift[SIZE_W-1:0];
        q_nxt   = {q_r[FIT_W-2:0], div_ge};
        cnt_nxt = cnt_r + STW'(1);
        if (cnt_r == STW'(FIT_W - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      // Saturating add and store of the kept genome
      ST_ACC: begin
        run_nxt   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        mem_we    = 1'b1;
        mem_wsum  = run_nxt;
        kept_nxt  = kept_r + KW'(1);
        state_nxt = ST_LFIN;
      end
      ST_LFIN: begin
        if (last_r) begin
          load_open_nxt = 1'b0;
          res_kind_nxt  = ANS_LOAD;
          res_pos_nxt   = '0;
          res_ok_nxt    = (kept_r != '0);
          state_nxt     = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      // Fetch the sums bounding the range
      ST_SEL_LO: begin
        sum_raddr = AW'(start_r) - AW'(1);
        state_nxt = ST_SEL_HI;
      end
      ST_SEL_HI: begin
        sum_raddr = AW'(end_m1);
        lo_nxt    = (start_r == '0) ? '0 : sum_rd_r;
        state_nxt = ST_SEL_HW;
      end
      ST_SEL_HW: begin
        hi_nxt  = sum_rd_r;
        mc_nxt  = (lo_r < sum_rd_r) ? PW'(sum_rd_r - lo_r) : PW'(CW'(end_r) - CW'(start_r));
        acc_nxt = '0;
        cnt_nxt = '0;
        state_nxt = ST_MUL;
      end
      // Shift-add multiply by the random fraction
      ST_MUL: begin
        if (rf_r[0]) begin
          acc_nxt = acc_r + mc_r;
        end
        mc_nxt  = mc_r << 1;
        rf_nxt  = rf_r >> 1;
        cnt_nxt = cnt_r + STW'(1);
        if (cnt_r == STW'(FRACTION_BITS - 1)) begin
          state_nxt = ST_MULD;
        end
      end
      ST_MULD: begin
        if (lo_r < hi_r) begin
          v_nxt     = lo_r + prod;
          idx_nxt   = AW'(start_r);
          state_nxt = ST_SRD;
        end else begin
          idx_nxt   = AW'(pick);
          state_nxt = ST_PRD;
        end
      end
      // Linear scan for the first sum above the draw
      ST_SRD: begin
        sum_raddr = idx_r;
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if ((v_r < sum_rd_r) || (CW'(idx_r) == end_m1)) begin
          state_nxt = ST_PRD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_SRD;
        end
      end
      ST_PRD: begin
        pos_raddr = idx_r;
        state_nxt = ST_PWT;
      end
      ST_PWT: begin
        res_kind_nxt = ANS_SELECT;
        res_pos_nxt  = pos_rd_r;
        res_ok_nxt   = 1'b1;
        state_nxt    = ST_OUT;
      end
      // Hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_pos_nxt   = res_pos_r;
          out_kept_nxt  = KEPT_W'(kept_r);
          out_ok_nxt    = res_ok_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      skip_r      <= 1'b0;
      load_open_r <= 1'b0;
      kept_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_open_r <= load_open_nxt;
      kept_r      <= kept_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    size_r     <= size_nxt;
    last_r     <= last_nxt;
    rf_r       <= rf_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    v_r        <= v_nxt;
    acc_r      <= acc_nxt;
    mc_r       <= mc_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    res_kind_r <= res_kind_nxt;
    res_pos_r  <= res_pos_nxt;
    res_ok_r   <= res_ok_nxt;
    out_kind_r <= out_kind_nxt;
    out_pos_r  <= out_pos_nxt;
    out_kept_r <= out_kept_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {2'b00, out_ok_r, out_kept_r, out_pos_r};

  // Checks
  `SFRS_ASSERT_IMP(a_kept_bound, clk, rst_n, 1'b1, kept_r <= KW'(MAX_GENOMES))
  `SFRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_tready,
                   out_valid_r && $stable(out_tdata) && $stable(out_tuser))
  `SFRS_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == ST_SCMP,
                   CW'(idx_r) <= end_m1)
  `SFRS_ASSERT_NXT(a_open_select_rejected, clk, rst_n,
                   in_acc && (in_tuser == REQ_SELECT) && load_open_r,
                   (state_r == ST_OUT) && !res_ok_r)

endmodule

`default_nettype wire

// ===== verif/shared_fitness_roulette_select_unit_tb.sv =====
// Self-checking testbench for shared_fitness_roulette_select_unit: load runs and
// roulette selections with a built-in predictor and randomised stream idling.
// Depends on sfrs_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module shared_fitness_roulette_select_unit_tb;
  import sfrs_pkg::*;

  localparam int NGEN = MAX_GENOMES_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [FIT_W-1:0] fitness;
    logic [SIZE_W-1:0] size;
    logic             repro;
    logic             last;
    logic [RAND_W-1:0] frac;
    logic [START_W-1:0] rstart;
    logic [END_W-1:0] rend;
  } request_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [KEPT_W-1:0] kept;
    logic             ok;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  // Set when the request on the bus was taken at the last rising edge.
  logic in_taken_r = 1'b0;

  // Predictor state.
  logic [SUM_W-1:0] wheel_sum [NGEN];
  logic [POS_W-1:0] wheel_pos [NGEN];
  logic [SUM_W-1:0] acc_sum = '0;
  int unsigned kept_n = 0;
  logic load_open = 1'b0;
  logic skip_stagnant;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int send_idle_pct, recv_stall_pct;
  int error_count = 0;
  int answers_seen = 0;
  int cycle_count = 0;
  int loads_done = 0;
  int selects_done = 0;

  shared_fitness_roulette_select_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Append one request to the stimulus queue.
  task automatic queue_request(input request_t rq);
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  // Apply one accepted request to the predictor.
  task automatic predict_request(input request_t rq);
    answer_t ans;
    logic [SUM_W-1:0] w, lo, hi, v, span;
    logic [SUM_W+RAND_W:0] sum_wide;
    int unsigned pick, cnt;
    if (rq.kind == REQ_LOAD) begin
      if (!load_open) begin
        acc_sum = '0;
        kept_n = 0;
        load_open = 1'b1;
      end
      if (rq.fitness != 0 && (!skip_stagnant || rq.repro) && kept_n < NGEN) begin
        w = (rq.size != 0) ? SUM_W'(rq.fitness / rq.size) : SUM_W'(rq.fitness);
        sum_wide = acc_sum + w;
        acc_sum = (sum_wide > SUM_TOP) ? SUM_TOP : sum_wide[SUM_W-1:0];
        wheel_sum[kept_n] = acc_sum;
        wheel_pos[kept_n] = rq.position;
        kept_n++;
      end
      if (!rq.last) return;
      load_open = 1'b0;
      ans = '{ANS_LOAD, '0, KEPT_W'(kept_n), kept_n != 0};
    end else begin
      ans = '{ANS_SELECT, '0, KEPT_W'(kept_n), 1'b0};
      if (!load_open && rq.rstart < rq.rend && rq.rend <= kept_n) begin
        lo = (rq.rstart == 0) ? '0 : wheel_sum[rq.rstart-1];
        hi = wheel_sum[rq.rend-1];
        if (lo < hi) begin
          span = hi - lo;
          sum_wide = (span * rq.frac) >> FB;
          v = lo + sum_wide[SUM_W-1:0];
          pick = rq.rend - 1;
          for (int i = rq.rstart; i < rq.rend; i++)
            if (v < wheel_sum[i]) begin
              pick = i;
              break;
            end
        end else begin
          cnt = rq.rend - rq.rstart;
          pick = rq.rstart + ((cnt * rq.frac) >> FB);
          if (pick >= rq.rend) pick = rq.rend - 1;
        end
        ans.position = wheel_pos[pick];
        ans.ok = 1'b1;
      end
    end
    expected_answers.insert(expected_answers.size(), ans);
  endtask

  // Driver: presents queued requests, changing inputs at the falling edge.
  always @(negedge clk) begin
    request_t rq;
    if (rst_n && in_tvalid && !in_taken_r) begin
      // hold the current request until it is taken
    end else if (pending_requests.size() != 0 && rst_n &&
                 $urandom_range(99) >= send_idle_pct) begin
      rq = pending_requests.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= rq.kind;
      in_tlast <= rq.last;
      in_tdata <= {6'b0, rq.rend, rq.rstart, rq.frac, rq.repro, rq.size,
                   rq.fitness, rq.position};
    end else begin
      in_tvalid <= 1'b0;
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: samples handshakes at the rising edge.
  always @(posedge clk) begin
    answer_t got, want;
    request_t rq;
    cycle_count <= cycle_count + 1;
    in_taken_r <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      rq.kind = in_tuser;
      rq.last = in_tlast;
      {rq.rend, rq.rstart, rq.frac, rq.repro, rq.size, rq.fitness, rq.position} =
        in_tdata[89:0];
      predict_request(rq);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[9:0], out_tdata[20:10], out_tdata[21]};
      answers_seen++;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: kind %0d position %0d", got.kind, got.position);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        if (got.kind != want.kind) begin
          $error("answer_kind: expected %0d, got %0d", want.kind, got.kind);
          error_count++;
        end
        if (got.position != want.position) begin
          $error("selected_position: expected %0d, got %0d", want.position, got.position);
          error_count++;
        end
        if (got.kept != want.kept) begin
          $error("kept_count: expected %0d, got %0d", want.kept, got.kept);
          error_count++;
        end
        if (got.ok != want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok);
          error_count++;
        end
        if (want.kind == ANS_LOAD) loads_done++;
        else selects_done++;
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk)
    if (cycle_count > CYCLE_LIMIT) begin
      $display("shared_fitness_roulette_select_unit regression: fail");
      $finish;
    end

  function automatic request_t load_req(input logic [POS_W-1:0] p,
      input logic [FIT_W-1:0] f, input logic [SIZE_W-1:0] s, input logic r,
      input logic l);
    request_t rq;
    rq = '0;
    rq.kind = REQ_LOAD;
    rq.position = p;
    rq.fitness = f;
    rq.size = s;
    rq.repro = r;
    rq.last = l;
    // unused select fields carry noise so every select bit of tdata toggles
    rq.frac = RAND_W'($urandom);
    rq.rstart = START_W'($urandom);
    rq.rend = END_W'($urandom);
    return rq;
  endfunction

  function automatic request_t select_req(input logic [RAND_W-1:0] fr,
      input int unsigned st, input int unsigned en);
    request_t rq;
    rq = '0;
    rq.kind = REQ_SELECT;
    rq.frac = fr;
    rq.rstart = START_W'(st);
    rq.rend = END_W'(en);
    rq.position = POS_W'($urandom);
    rq.fitness = $urandom;
    rq.size = SIZE_W'($urandom);
    rq.repro = 1'($urandom);
    rq.last = 1'($urandom);
    return rq;
  endfunction

  // Random fitness: mostly modest, sometimes zero or huge.
  function automatic logic [FIT_W-1:0] rand_fitness();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(3) + 1;
      default: return $urandom_range(32'h0004_0000, 1);
    endcase
  endfunction

  // Queue one load run of n genomes.
  task automatic queue_load(input int n, input int size_max);
    for (int i = 0; i < n; i++)
      queue_request(load_req(POS_W'($urandom), rand_fitness(),
        ($urandom_range(3) == 0) ? SIZE_W'(0) : SIZE_W'($urandom_range(size_max)),
        $urandom_range(3) != 0, i == n - 1));
  endtask

  task automatic wait_drained();
    wait (pending_requests.size() == 0 && !in_tvalid);
    wait (expected_answers.size() == 0);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_skip(input logic value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    skip_stagnant = value;
  endtask

  initial begin
    int n_load;
    skip_stagnant = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: select before any load, extremes, zero and stagnant genomes.
    queue_request(select_req(16'h0000, 0, 1));
    queue_request(load_req(10'h3FF, 32'hFFFF_FFFF, 0, 1, 0));
    queue_request(select_req(16'h8000, 0, 1));
    queue_request(load_req(10'h000, 32'h0, 5, 1, 0));
    queue_request(load_req(10'h155, 32'h0001_0000, 10'h3FF, 0, 0));
    queue_request(load_req(10'h2AA, 32'hFFFF_FFFF, 1, 1, 1));
    queue_request(select_req(16'h0000, 0, 3));
    queue_request(select_req(16'hFFFF, 0, 3));
    queue_request(select_req(16'h7FFF, 1, 3));
    queue_request(select_req(16'h1234, 2, 2));
    queue_request(select_req(16'h1234, 0, 4));
    queue_request(select_req(16'hFFFF, 10'h3FF, 11'h400));
    // equal sums: tiny fitness divided by a big species gives zero weight
    queue_request(load_req(10'd7, 32'd3, 10'd500, 1, 0));
    queue_request(load_req(10'd8, 32'd2, 10'd900, 1, 0));
    queue_request(load_req(10'd9, 32'd1, 10'd3, 0, 1));
    queue_request(select_req(16'hFFFF, 0, 3));
    queue_request(select_req(16'h5555, 0, 3));
    // load of only zero fitness
    queue_request(load_req(10'd1, 32'd0, 10'd0, 1, 1));
    queue_request(select_req(16'h0, 0, 1));
    wait_drained();

    // Stagnant skipping on, then store-full run of 1030 cheap genomes.
    write_skip(1'b1);
    queue_request(load_req(10'd4, 32'd100, 0, 0, 0));
    queue_request(load_req(10'd5, 32'd100, 0, 1, 1));
    queue_request(select_req(16'h4000, 0, 1));
    wait_drained();
    write_skip(1'b0);
    for (int i = 0; i < 1030; i++)
      queue_request(load_req(POS_W'(i), 32'hFFFF_FFFF, 0, 1, i == 1029));
    queue_request(select_req(16'hFFFF, 1000, 1024));
    queue_request(select_req(16'h0100, 1020, 1024));
    wait_drained();

    // Random phases under four idling patterns and both register values.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 81; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      write_skip(phase >= 4);
      for (int run = 0; run < 3; run++) begin
        n_load = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
        queue_load(n_load, ($urandom_range(1) == 0) ? 4 : 10'h3FF);
        // mostly ranges within the load; some may be invalid after skips
        for (int k = 0; k < 14; k++) begin
          int unsigned st, en;
          if ($urandom_range(9) == 0) begin
            st = $urandom_range(1023);
            en = $urandom_range(1024, 1);
          end else begin
            en = $urandom_range(n_load, 1);
            st = $urandom_range(en - 1);
          end
          queue_request(select_req(RAND_W'($urandom), st, en));
        end
        // occasionally a select slips in while a load is still open
        if ($urandom_range(3) == 0) begin
          queue_request(load_req(POS_W'($urandom), rand_fitness(), 2, 1, 0));
          queue_request(select_req(RAND_W'($urandom), 0, 1));
          queue_request(load_req(POS_W'($urandom), rand_fitness(), 0, 1, 1));
        end
      end
      wait_drained();
    end

    $display("Covered %0d load reports and %0d selections over %0d results.",
             loads_done, selects_done, answers_seen);
    $display("Idling patterns: none, sender-heavy, receiver-heavy and mixed.");
    if (error_count == 0 && expected_answers.size() == 0)
      $display("shared_fitness_roulette_select_unit regression: pass");
    else
      $display("shared_fitness_roulette_select_unit regression: fail");
    $finish;
  end
endmodule
